[rtl/mck_pkg.sv]
// Shared types, constants and code tables for the Morse character keyer.
package mck_pkg;

  localparam int UnitW  = 16;
  localparam int TicksW = 18;

  localparam logic [1:0] Units1 = 2'd1;
  localparam logic [1:0] Units3 = 2'd3;

  localparam logic [1:0] ElemDash = 2'b11;

  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharBang  = 8'h21;
  localparam logic [7:0] CharAt    = 8'h40;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpZ   = 8'h5A;
  localparam logic [7:0] CharUndsc = 8'h5F;
  localparam logic [7:0] CharLoA   = 8'h61;
  localparam logic [7:0] CharLoZ   = 8'h7A;
  localparam logic [7:0] CharH     = 8'h48;
  localparam logic [7:0] CharK     = 8'h4B;
  localparam logic [7:0] CharU     = 8'h55;

  // one E: a single dot
  localparam logic [7:0] ErrCode   = 8'h01;
  // four E in an error word
  localparam logic [1:0] ErrRepeat = 2'd3;

  localparam logic [15:0] UnitReset = 16'd100;

  // digraphs for '!' to '@', two letters each
  localparam logic [0:63][7:0] PairTable =
    "KWRRHHSXHHASWGNGKKHHARGWDURKNROMWMUMSMHTEHTHMSOIONOSKRHHNUHHUDAC";

  typedef enum logic {
    StIdle,
    StSend
  } seq_state_e;

  // element plan for one character
  typedef struct packed {
    logic [7:0] code_a;
    logic [7:0] code_b;
    logic       gap;
    logic       err;
  } plan_t;

  typedef struct packed {
    logic       valid;
    logic       light_on;
    logic [1:0] units;
    logic       last;
  } seg_t;

  // packed element code of an uppercase letter, 2 bits per element, LSB first
  function automatic logic [7:0] letter_code(input logic [7:0] ch);
    logic [7:0] idx;
    idx = ch - CharUpA;
    case (idx)
      8'd0:    letter_code = 8'h0D;
      8'd1:    letter_code = 8'h57;
      8'd2:    letter_code = 8'h77;
      8'd3:    letter_code = 8'h17;
      8'd4:    letter_code = 8'h01;
      8'd5:    letter_code = 8'h75;
      8'd6:    letter_code = 8'h1F;
      8'd7:    letter_code = 8'h55;
      8'd8:    letter_code = 8'h05;
      8'd9:    letter_code = 8'hFD;
      8'd10:   letter_code = 8'h37;
      8'd11:   letter_code = 8'h5D;
      8'd12:   letter_code = 8'h0F;
      8'd13:   letter_code = 8'h07;
      8'd14:   letter_code = 8'h3F;
      8'd15:   letter_code = 8'h7D;
      8'd16:   letter_code = 8'hDF;
      8'd17:   letter_code = 8'h1D;
      8'd18:   letter_code = 8'h15;
      8'd19:   letter_code = 8'h03;
      8'd20:   letter_code = 8'h35;
      8'd21:   letter_code = 8'hD5;
      8'd22:   letter_code = 8'h3D;
      8'd23:   letter_code = 8'hD7;
      8'd24:   letter_code = 8'hF7;
      8'd25:   letter_code = 8'h5F;
      default: letter_code = 8'h00;
    endcase
  endfunction

endpackage

[rtl/morse_character_keyer.sv]
// Top level of the Morse character keyer: config register, decoder, sequencer, output word.
// A character is taken when start_i is high and busy_o low. It then yields one segment word
// per clock, 2 to 16 words, each shown for one cycle with valid_o high. The start is first
// registered into the sequencer state, then each segment into the output word register;
// busy_o drops in the cycle the last word is shown. The rate is set by the sequencer, which
// shifts the letter codes out two bits per element and forms one segment per cycle. The
// receiver cannot stall: every word must be taken in the cycle it is shown. unit_length
// resets to 100 and should only be written while busy_o is low and no words are pending.
module morse_character_keyer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [7:0]  character_i,
  input  logic        unit_length_we_i,
  input  logic [15:0] unit_length_i,
  output logic        valid_o,
  output logic        light_on_o,
  output logic [1:0]  units_o,
  output logic [17:0] ticks_o,
  output logic        last_segment_o
);
  import mck_pkg::*;

  logic [UnitW-1:0]  unit_q;
  plan_t             plan;
  seg_t              seg;
  logic [TicksW-1:0] ticks_d;
  logic              valid_q;
  logic              light_on_q;
  logic [1:0]        units_q;
  logic [TicksW-1:0] ticks_q;
  logic              last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q <= UnitReset;
    end else if (unit_length_we_i) begin
      unit_q <= unit_length_i;
    end
  end

  mck_decode u_decode (
    .character_i (character_i),
    .plan_o      (plan)
  );

  mck_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .plan_i  (plan),
    .busy_o  (busy_o),
    .seg_o   (seg)
  );

  // 3 units = 2*unit + unit
  assign ticks_d = (seg.units == Units3)
                 ? ({1'b0, unit_q, 1'b0} + {2'b00, unit_q})
                 : {2'b00, unit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= seg.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    light_on_q <= seg.light_on;
    units_q    <= seg.units;
    ticks_q    <= ticks_d;
    last_q     <= seg.last;
  end

  assign valid_o        = valid_q;
  assign light_on_o     = light_on_q;
  assign units_o        = units_q;
  assign ticks_o        = ticks_q;
  assign last_segment_o = last_q;

endmodule

[rtl/mck_decode.sv]
// Character decoder: maps one ASCII code to its letter codes and gap and error flags.
module mck_decode (
  input  logic [7:0]     character_i,
  output mck_pkg::plan_t plan_o
);
  import mck_pkg::*;

  logic [4:0] pair_idx;
  logic [7:0] pair_a;
  logic [7:0] pair_b;
  plan_t      err_plan;

  assign pair_idx = 5'(character_i - CharBang);
  assign pair_a   = PairTable[{pair_idx, 1'b0}];
  assign pair_b   = PairTable[{pair_idx, 1'b1}];

  always_comb begin
    err_plan        = '0;
    err_plan.code_a = ErrCode;
    err_plan.gap    = 1'b1;
    err_plan.err    = 1'b1;
  end

  always_comb begin
    plan_o = '0;
    if (character_i == CharSpace) begin
      plan_o.gap = 1'b1;
    end else if (character_i inside {[CharBang:CharAt]}) begin
      if (pair_a == CharH && pair_b == CharH) begin
        plan_o = err_plan;
      end else begin
        plan_o.code_a = letter_code(pair_a);
        plan_o.code_b = letter_code(pair_b);
        plan_o.gap    = 1'b1;
      end
    end else if (character_i inside {[CharUpA:CharUpZ]}) begin
      plan_o.code_a = letter_code(character_i);
    end else if (character_i == CharUndsc) begin
      plan_o.code_a = letter_code(CharU);
      plan_o.code_b = letter_code(CharK);
      plan_o.gap    = 1'b1;
    end else if (character_i inside {[CharLoA:CharLoZ]}) begin
      plan_o.code_a = letter_code(character_i - 8'h20);
    end else begin
      plan_o = err_plan;
    end
  end

endmodule

[rtl/mck_seq.sv]
// Segment sequencer: shifts element codes out two bits at a time, one segment per cycle.
module mck_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  mck_pkg::plan_t plan_i,
  output logic           busy_o,
  output mck_pkg::seg_t  seg_o
);
  import mck_pkg::*;

  seq_state_e state_q, state_d;
  logic [7:0] code_a_q, code_a_d;
  logic [7:0] code_b_q, code_b_d;
  logic       gap_q, gap_d;
  logic [1:0] err_left_q, err_left_d;
  logic       phase_q, phase_d;
  logic [1:0] elem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      code_a_q   <= '0;
      code_b_q   <= '0;
      gap_q      <= 1'b0;
      err_left_q <= '0;
      phase_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      code_a_q   <= code_a_d;
      code_b_q   <= code_b_d;
      gap_q      <= gap_d;
      err_left_q <= err_left_d;
      phase_q    <= phase_d;
    end
  end

  assign elem = (code_a_q != '0) ? code_a_q[1:0] : code_b_q[1:0];

  always_comb begin
    state_d    = state_q;
    code_a_d   = code_a_q;
    code_b_d   = code_b_q;
    gap_d      = gap_q;
    err_left_d = err_left_q;
    phase_d    = phase_q;
    seg_o      = '0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          state_d    = StSend;
          code_a_d   = plan_i.code_a;
          code_b_d   = plan_i.code_b;
          gap_d      = plan_i.gap;
          err_left_d = plan_i.err ? ErrRepeat : 2'd0;
          phase_d    = 1'b0;
        end
      end
      StSend: begin
        seg_o.valid = 1'b1;
        if (code_a_q != '0 || code_b_q != '0) begin
          if (!phase_q) begin
            seg_o.light_on = 1'b1;
            seg_o.units    = (elem == ElemDash) ? Units3 : Units1;
            phase_d        = 1'b1;
          end else begin
            seg_o.units = Units1;
            phase_d     = 1'b0;
            if (code_a_q != '0) begin
              code_a_d = code_a_q >> 2;
            end else begin
              code_b_d = code_b_q >> 2;
            end
          end
        end else if (gap_q) begin
          seg_o.units = Units3;
          if (err_left_q != '0) begin
            code_a_d   = ErrCode;
            err_left_d = err_left_q - 2'd1;
          end else begin
            gap_d = 1'b0;
          end
        end else begin
          seg_o.units = Units3;
          seg_o.last  = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign busy_o = (state_q != StIdle);

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_o.last |=> (state_q == StIdle))
    else $error("sequencer still busy after last segment");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && state_q == StIdle) |=> (state_q == StSend))
    else $error("start not taken");

  a_on_then_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seg_o.valid && seg_o.light_on) |=> (seg_o.valid && !seg_o.light_on
                                         && seg_o.units == Units1))
    else $error("keyed element not followed by one-unit space");

  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_o.last |-> (!seg_o.light_on && seg_o.units == Units3))
    else $error("last segment is not a letter gap");

  a_phase_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (state_q == StSend))
    else $error("element half-sent while idle");

endmodule

[verif/testbench.sv]
// Self-checking testbench for morse_character_keyer: drives characters, predicts segment words.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mck_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned MAX_PRINTS   = 30;
  localparam int unsigned RANDOM_ITEMS = 16;

  // element codes of A..Z, two bits per element, first element in the low bits
  localparam logic [7:0] LETTER_CODES [0:25] = '{
    8'h0D, 8'h57, 8'h77, 8'h17, 8'h01, 8'h75, 8'h1F, 8'h55, 8'h05, 8'hFD, 8'h37, 8'h5D,
    8'h0F, 8'h07, 8'h3F, 8'h7D, 8'hDF, 8'h1D, 8'h15, 8'h03, 8'h35, 8'hD5, 8'h3D, 8'hD7,
    8'hF7, 8'h5F
  };

  // letter pairs sent for '!' to '@', first letter in the top byte
  localparam logic [511:0] DIGRAPHS =
    "KWRRHHSXHHASWGNGKKHHARGWDURKNROMWMUMSMHTEHTHMSOIONOSKRHHNUHHUDAC";

  typedef struct packed {
    logic        light_on;
    logic [1:0]  units;
    logic [17:0] ticks;
    logic        last_segment;
  } seg_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [7:0]  character_i = '0;
  logic        unit_length_we_i = 1'b0;
  logic [15:0] unit_length_i = '0;
  logic        valid_o;
  logic        light_on_o;
  logic [1:0]  units_o;
  logic [17:0] ticks_o;
  logic        last_segment_o;

  logic [7:0]  char_queue [$];
  seg_word_t   pending_segs [$];
  logic [15:0] unit_len = UnitReset;
  logic        word_taken = 1'b0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 1;
  int unsigned cycle_count = 0;
  int unsigned err_count = 0;
  int unsigned chars_sent = 0;
  int unsigned segs_checked = 0;
  int unsigned settings_used = 1;

  morse_character_keyer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .character_i      (character_i),
    .unit_length_we_i (unit_length_we_i),
    .unit_length_i    (unit_length_i),
    .valid_o          (valid_o),
    .light_on_o       (light_on_o),
    .units_o          (units_o),
    .ticks_o          (ticks_o),
    .last_segment_o   (last_segment_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_count < MAX_PRINTS) begin
      $display("MISMATCH cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
    end
    err_count++;
  endtask

  // --- segment predictor ---

  function automatic void push_seg(input logic on, input logic [1:0] u);
    seg_word_t  s;
    logic [33:0] prod;
    prod = 34'(u) * 34'(unit_len);
    s.light_on     = on;
    s.units        = u;
    s.ticks        = prod[17:0];
    s.last_segment = 1'b0;
    pending_segs.push_back(s);
  endfunction

  function automatic void push_code(input logic [7:0] code);
    logic [7:0] c;
    c = code;
    while (c != 8'h00) begin
      push_seg(1'b1, (c[1:0] == ElemDash) ? Units3 : Units1);
      push_seg(1'b0, Units1);
      c = c >> 2;
    end
  endfunction

  function automatic void push_letter(input logic [7:0] ch);
    logic [7:0] idx;
    idx = ch - CharUpA;
    if (idx < 8'd26) push_code(LETTER_CODES[5'(idx)]);
  endfunction

  function automatic void push_error();
    for (int k = 0; k < 4; k++) begin
      push_code(ErrCode);
      push_seg(1'b0, Units3);
    end
  endfunction

  function automatic void push_pair(input logic [7:0] a, input logic [7:0] b);
    if (a == CharH && b == CharH) begin
      push_error();
    end else begin
      push_letter(a);
      push_letter(b);
      push_seg(1'b0, Units3);
    end
  endfunction

  function automatic void key_character(input logic [7:0] c);
    seg_word_t  tail;
    logic [4:0] idx;
    if (c[7] || c < CharSpace) begin
      push_error();
    end else if (c == CharSpace) begin
      push_seg(1'b0, Units3);
    end else if (c < CharUpA) begin
      idx = 5'(c - CharBang);
      push_pair(DIGRAPHS[511 - 16 * idx -: 8], DIGRAPHS[503 - 16 * idx -: 8]);
    end else if (c <= CharUpZ) begin
      push_letter(c);
    end else if (c == CharUndsc) begin
      push_pair(CharU, CharK);
    end else if (c >= CharLoA && c <= CharLoZ) begin
      push_letter(c - CharLoA + CharUpA);
    end else begin
      push_error();
    end
    push_seg(1'b0, Units3);
    tail = pending_segs.pop_back();
    tail.last_segment = 1'b1;
    pending_segs.push_back(tail);
  endfunction

  // --- driver: bursts of characters with random gaps ---

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (start_i && !word_taken) begin
      // hold the word until busy_o lets it in
    end else if (gap_left > 0) begin
      gap_left    <= gap_left - 1;
      start_i     <= 1'b0;
      character_i <= 8'($urandom);
    end else if (char_queue.size() != 0) begin
      start_i     <= 1'b1;
      character_i <= char_queue.pop_front();
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 8);
        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 22);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      start_i     <= 1'b0;
      character_i <= 8'($urandom);
    end
  end

  // --- monitor and checker ---

  always @(posedge clk_i) begin
    seg_word_t got;
    seg_word_t want;
    cycle_count++;
    word_taken = rst_ni && start_i && !busy_o;
    if (rst_ni) begin
      if (unit_length_we_i) unit_len = unit_length_i;
      if (valid_o === 1'b1) begin
        got = '{light_on_o, units_o, ticks_o, last_segment_o};
        segs_checked++;
        if (pending_segs.size() == 0) begin
          report_mismatch("unexpected word", 32'(got), 32'd0);
        end else begin
          want = pending_segs.pop_front();
          if (got.light_on !== want.light_on)
            report_mismatch("light_on", 32'(got.light_on), 32'(want.light_on));
          if (got.units !== want.units)
            report_mismatch("units", 32'(got.units), 32'(want.units));
          if (got.ticks !== want.ticks)
            report_mismatch("ticks", 32'(got.ticks), 32'(want.ticks));
          if (got.last_segment !== want.last_segment)
            report_mismatch("last_segment", 32'(got.last_segment),
                            32'(want.last_segment));
        end
      end
      if (word_taken) begin
        key_character(character_i);
        chars_sent++;
      end
    end
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d words outstanding",
               cycle_count, pending_segs.size());
      $display("morse_character_keyer verification failed");
      $finish;
    end
  end

  // --- stimulus sequencing ---

  task automatic wait_drained();
    do @(posedge clk_i);
    while (char_queue.size() != 0 || start_i || busy_o || pending_segs.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_unit_length(input logic [15:0] value);
    @(negedge clk_i);
    unit_length_we_i <= 1'b1;
    unit_length_i    <= value;
    @(negedge clk_i);
    unit_length_we_i <= 1'b0;
    unit_length_i    <= 16'($urandom);
    settings_used++;
  endtask

  function automatic logic [7:0] random_character();
    case ($urandom_range(0, 9))
      0, 1:    return 8'($urandom_range(CharUpA, CharUpZ));
      2, 3:    return 8'($urandom_range(CharLoA, CharLoZ));
      4, 5:    return 8'($urandom_range(CharBang, CharAt));
      6:       return ($urandom_range(0, 1) == 0) ? CharSpace : CharUndsc;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] unit_settings [$];
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed set at the reset unit length
    char_queue = '{8'h00, 8'hFF, 8'h1F, 8'h7F, 8'h80, CharSpace, CharBang, CharAt,
                   8'h23, 8'h25, CharUpA, CharUpZ, 8'h4A, 8'h59, CharLoA, CharLoZ,
                   CharUndsc, 8'h5B, 8'h60, 8'h7B, 8'h3A, 8'h33, 8'h55};
    wait_drained();

    unit_settings = '{16'hFFFF, 16'h0001, 16'hAAAA, 16'($urandom_range(2, 65534)),
                      16'h5555, 16'($urandom_range(2, 300))};
    foreach (unit_settings[i]) begin
      load_unit_length(unit_settings[i]);
      for (int n = 0; n < RANDOM_ITEMS; n++) char_queue.push_back(random_character());
      wait_drained();
    end

    repeat (30) @(posedge clk_i);
    if (pending_segs.size() != 0)
      report_mismatch("words never produced", 32'(pending_segs.size()), 32'd0);

    $display("sent %0d characters over %0d unit lengths, checked %0d segment words",
             chars_sent, settings_used, segs_checked);
    if (err_count == 0) begin
      $display("morse_character_keyer verification clean");
    end else begin
      $display("%0d mismatches", err_count);
      $display("morse_character_keyer verification failed");
    end
    $finish;
  end

endmodule
